// ----- sv/ocvm_pkg.sv -----
package ocvm_pkg;

  localparam int IN_W   = 40;
  localparam int OUT_W  = 168;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 32;

  localparam logic [CIDX_W-1:0] REG_TX    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_TY    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_TZ    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_RAD   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_POLAR = 3'd4;
  localparam logic [CIDX_W-1:0] REG_AZ    = 3'd5;

  localparam logic [15:0] POLAR_MIN = 16'd1280;
  localparam logic [15:0] POLAR_MAX = 16'd44800;
  localparam logic [15:0] POLAR_RST = 16'd23040;
  localparam logic [30:0] RAD_RST   = 31'd655360;

  localparam logic signed [19:0] DEG360_S = 20'sd92160;
  localparam logic signed [19:0] DEG720_S = 20'sd184320;
  localparam logic [16:0] DEG90  = 17'd23040;
  localparam logic [16:0] DEG180 = 17'd46080;
  localparam logic [16:0] DEG270 = 17'd69120;
  localparam logic [16:0] DEG360 = 17'd92160;
  localparam logic [16:0] DEG45  = 17'd11520;

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;
  localparam logic [63:0] K_HI    = PI_Q60 / 64'd46080;
  localparam logic [63:0] K_LO    = PI_Q60 % 64'd46080;
  localparam logic [15:0] DIV_RAD = 16'd46080;
  localparam logic [3:0]  TERMS   = 4'd12;

endpackage

// ----- sv/orbit_camera_view_matrix_core.sv -----
// Orbit camera view matrix core.
// Config: cfg_we_i/cfg_idx_i/cfg_data_i write one register per cycle (target x/y/z,
// radius, start polar, start azimuth); a polar or azimuth write reloads that angle.
// Write only while idle.
// Input stream s_axis: one transaction carries the azimuth and polar deltas.
// Output stream m_axis: four transactions per input, rows 0..3 of the view
// matrix (tuser = row index, tlast on row 3), each with the updated angles.
// Sine/cosine come from a Taylor series in Q60 run on one shared 33x33
// multiplier; a division by a series constant is a reciprocal multiply, a
// back multiply and one correction. The polar angle is evaluated first, then
// the azimuth, then the sine/cosine products; rows 0..2 each sum the target
// products, row 3 follows row 2, and the next input is accepted once row 3
// has been registered.
// s_axis_tready is high only while the sequencer is idle.
// The output register holds a row until taken; a stalled receiver stops the
// sequencer at the next row. Row 3 may wait while the next input is accepted.
// Reset: targets 0, radius 10.0, polar 90 degrees, azimuth 0, no output pending.
module orbit_camera_view_matrix_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ocvm_pkg::CIDX_W-1:0]     cfg_idx_i,
  input  logic [ocvm_pkg::CDAT_W-1:0]     cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // delta_azimuth[17:0], delta_polar[35:18], zero pad
  input  logic [ocvm_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // col0[31:0], col1[63:32], col2[95:64], col3[127:96], cur_polar[143:128],
  // cur_azimuth[161:144], zero pad
  output logic [ocvm_pkg::OUT_W-1:0]      m_axis_tdata,
  // row_index[1:0]
  output logic [1:0]                      m_axis_tuser,
  output logic                            m_axis_tlast
);
  import ocvm_pkg::*;

  localparam int TW = FRAC_BITS + 2;
  localparam logic [64:0] TWO64 = 65'h1_0000_0000_0000_0000;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RED  = 5'd1;
  localparam logic [4:0] S_XB   = 5'd2;
  localparam logic [4:0] S_XC   = 5'd3;
  localparam logic [4:0] S_XD   = 5'd4;
  localparam logic [4:0] S_X2   = 5'd5;
  localparam logic [4:0] S_S2   = 5'd6;
  localparam logic [4:0] S_S3   = 5'd7;
  localparam logic [4:0] S_C2   = 5'd8;
  localparam logic [4:0] S_C3   = 5'd9;
  localparam logic [4:0] S_FIN  = 5'd10;
  localparam logic [4:0] S_PR   = 5'd11;
  localparam logic [4:0] S_TR   = 5'd12;
  localparam logic [4:0] S_TRE  = 5'd13;
  localparam logic [4:0] S_ROW3 = 5'd14;
  localparam logic [4:0] S_MQ   = 5'd15;
  localparam logic [4:0] S_DIV  = 5'd16;
  localparam logic [4:0] S_DV1  = 5'd17;
  localparam logic [4:0] S_DV2  = 5'd18;

  logic [4:0]  state_q, state_d, ret_q, ret_d, dret_q, dret_d;
  logic signed [31:0] tx_q, tx_d, ty_q, ty_d, tz_q, tz_d;
  logic [30:0] rad_q, rad_d;
  logic [15:0] pol_q, pol_d;
  logic signed [17:0] az_q, az_d;

  logic [63:0]  ma_q, ma_d, mb_q, mb_d;
  logic [127:0] acc_q, acc_d;
  logic [1:0]   cnt_q, cnt_d;
  logic [63:0]  dq_q, dq_d, nd_q, nd_d;
  logic [15:0]  dv_q, dv_d;
  logic [63:0]  rcp, dv_rem;

  logic [63:0] x_q, x_d, x2_q, x2_d, ts_q, ts_d, tc_q, tc_d, ss_q, ss_d, cc_q, cc_d;
  logic [3:0]  k_q, k_d;
  logic [13:0] r_q, r_d;
  logic        swap_q, swap_d, pass_q, pass_d;
  logic [1:0]  quad_q, quad_d;
  logic signed [TW-1:0] st_q, st_d, ct_q, ct_d, sp_q, sp_d, cp_q, cp_d;
  logic signed [TW-1:0] ctsp_q, ctsp_d, ctcp_q, ctcp_d, stsp_q, stsp_d, stcp_q, stcp_d;
  logic [1:0]  p_q, p_d, j_q, j_d, n_q, n_d;

  logic        ov_q, ov_d;
  logic [1:0]  oidx_q, oidx_d;
  logic signed [31:0] oc0_q, oc0_d, oc1_q, oc1_d, oc2_q, oc2_d, oc3_q, oc3_d;
  logic [15:0] opol_q, opol_d;
  logic signed [17:0] oaz_q, oaz_d;

  // shared multiplier
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  prod;
  logic [6:0]          sh;
  logic [127:0]        pp;

  logic signed [18:0] pol_sum;
  logic signed [19:0] az_sum;
  logic signed [17:0] daz, dpol;
  logic signed [18:0] ang;
  logic [16:0] m_ang, r_full;
  logic [1:0]  quad;
  logic [9:0]  d_s, d_c, k2;
  logic [63:0] mq, ss_r, cc_r;
  logic [TW-1:0] sf, cf, s0, c0, so, co;
  logic signed [TW-1:0] cf_j, tg_c;
  logic signed [31:0] tg;
  logic signed [63:0] rs, rr;
  logic signed [65:0] tv;
  logic signed [31:0] col3;
  logic signed [65:0] rp;
  logic out_free;

  assign daz  = s_axis_tdata[17:0];
  assign dpol = s_axis_tdata[35:18];
  assign prod = mul_a * mul_b;
  assign pp   = {{62{prod[65]}}, prod} << sh;
  assign mq   = acc_q[123:60];
  assign k2   = {5'b0, k_q, 1'b0};
  assign d_s  = k2 * (k2 + 10'd1);
  assign d_c  = k2 * (k2 - 10'd1);
  assign out_free = !ov_q || m_axis_tready;
  assign dv_rem = nd_q - acc_q[63:0];

  // floor(2^64 / d) for every divisor the series uses
  always_comb begin
    unique case (dv_q)
      DIV_RAD: rcp = 64'(TWO64 / 65'(DIV_RAD));
      16'd2:   rcp = 64'(TWO64 / 65'd2);
      16'd6:   rcp = 64'(TWO64 / 65'd6);
      16'd12:  rcp = 64'(TWO64 / 65'd12);
      16'd20:  rcp = 64'(TWO64 / 65'd20);
      16'd30:  rcp = 64'(TWO64 / 65'd30);
      16'd42:  rcp = 64'(TWO64 / 65'd42);
      16'd56:  rcp = 64'(TWO64 / 65'd56);
      16'd72:  rcp = 64'(TWO64 / 65'd72);
      16'd90:  rcp = 64'(TWO64 / 65'd90);
      16'd110: rcp = 64'(TWO64 / 65'd110);
      16'd132: rcp = 64'(TWO64 / 65'd132);
      16'd156: rcp = 64'(TWO64 / 65'd156);
      16'd182: rcp = 64'(TWO64 / 65'd182);
      16'd210: rcp = 64'(TWO64 / 65'd210);
      16'd240: rcp = 64'(TWO64 / 65'd240);
      16'd272: rcp = 64'(TWO64 / 65'd272);
      16'd306: rcp = 64'(TWO64 / 65'd306);
      16'd342: rcp = 64'(TWO64 / 65'd342);
      16'd380: rcp = 64'(TWO64 / 65'd380);
      16'd420: rcp = 64'(TWO64 / 65'd420);
      16'd462: rcp = 64'(TWO64 / 65'd462);
      16'd506: rcp = 64'(TWO64 / 65'd506);
      16'd552: rcp = 64'(TWO64 / 65'd552);
      16'd600: rcp = 64'(TWO64 / 65'd600);
      default: rcp = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sh    = '0;
    unique case (state_q)
      S_MQ: begin
        mul_a = {1'b0, cnt_q[0] ? ma_q[63:32] : ma_q[31:0]};
        mul_b = {1'b0, cnt_q[1] ? mb_q[63:32] : mb_q[31:0]};
        sh    = {cnt_q[0] & cnt_q[1], cnt_q[0] ^ cnt_q[1], 5'b0};
      end
      S_PR: begin
        mul_a = 33'(p_q[1] ? st_q : ct_q);
        mul_b = 33'(p_q[0] ? cp_q : sp_q);
      end
      S_TR: begin
        mul_a = 33'(tg);
        mul_b = 33'(tg_c);
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (n_q)
      2'd0:    tg = tx_q;
      2'd1:    tg = ty_q;
      default: tg = tz_q;
    endcase
    unique case ({j_q, n_q})
      4'b0000: tg_c = cp_q;
      4'b0001: tg_c = '0;
      4'b0010: tg_c = -sp_q;
      4'b0100: tg_c = -ctsp_q;
      4'b0101: tg_c = st_q;
      4'b0110: tg_c = -ctcp_q;
      4'b1000: tg_c = stsp_q;
      4'b1001: tg_c = ct_q;
      4'b1010: tg_c = stcp_q;
      default: tg_c = '0;
    endcase
  end

  always_comb begin
    // angle reduction to one quadrant
    ang   = pass_q ? 19'(az_q) : $signed({3'b0, pol_q});
    if (ang < 0)                  m_ang = 17'(ang + 19'(DEG360_S));
    else if (17'(ang) >= DEG360)  m_ang = 17'(ang) - DEG360;
    else                          m_ang = 17'(ang);
    if (m_ang < DEG90)       begin quad = 2'd0; r_full = m_ang;          end
    else if (m_ang < DEG180) begin quad = 2'd1; r_full = m_ang - DEG90;  end
    else if (m_ang < DEG270) begin quad = 2'd2; r_full = m_ang - DEG180; end
    else                     begin quad = 2'd3; r_full = m_ang - DEG270; end
    // series result to fraction bits
    ss_r = ss_q + (64'd1 << (59 - FRAC_BITS));
    cc_r = cc_q + (64'd1 << (59 - FRAC_BITS));
    sf   = TW'(ss_r[60-FRAC_BITS +: FRAC_BITS+1]);
    cf   = TW'(cc_r[60-FRAC_BITS +: FRAC_BITS+1]);
    s0   = swap_q ? cf : sf;
    c0   = swap_q ? sf : cf;
    unique case (quad_q)
      2'd0: begin so = s0;  co = c0;  end
      2'd1: begin so = c0;  co = -s0; end
      2'd2: begin so = -s0; co = -c0; end
      default: begin so = -c0; co = s0; end
    endcase
    cf_j = '0;
    rp   = prod + (66'sd1 <<< (FRAC_BITS - 1));
    rs   = $signed(acc_q[63:0]) + (64'sd1 <<< (FRAC_BITS - 1));
    rr   = rs >>> FRAC_BITS;
    tv   = -$signed({{2{rr[63]}}, rr}) - ((j_q == 2'd2) ? $signed({35'b0, rad_q}) : 66'sd0);
    if (tv > 66'sd2147483647)        col3 = 32'sh7FFFFFFF;
    else if (tv < -66'sd2147483648)  col3 = 32'sh80000000;
    else                             col3 = 32'(tv);
    pol_sum = $signed({3'b0, pol_q}) + 19'(dpol);
    az_sum  = 20'(az_q) + 20'(daz);
  end

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q; ret_d = ret_q; dret_d = dret_q;
    tx_d = tx_q; ty_d = ty_q; tz_d = tz_q; rad_d = rad_q; pol_d = pol_q; az_d = az_q;
    ma_d = ma_q; mb_d = mb_q; acc_d = acc_q; cnt_d = cnt_q;
    dq_d = dq_q; nd_d = nd_q; dv_d = dv_q;
    x_d = x_q; x2_d = x2_q; ts_d = ts_q; tc_d = tc_q; ss_d = ss_q; cc_d = cc_q;
    k_d = k_q; r_d = r_q; swap_d = swap_q; pass_d = pass_q; quad_d = quad_q;
    st_d = st_q; ct_d = ct_q; sp_d = sp_q; cp_d = cp_q;
    ctsp_d = ctsp_q; ctcp_d = ctcp_q; stsp_d = stsp_q; stcp_d = stcp_q;
    p_d = p_q; j_d = j_q; n_d = n_q;
    ov_d = ov_q; oidx_d = oidx_q; oc0_d = oc0_q; oc1_d = oc1_q; oc2_d = oc2_q;
    oc3_d = oc3_q; opol_d = opol_q; oaz_d = oaz_q;

    if (ov_q && m_axis_tready) ov_d = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TX:  tx_d  = cfg_data_i;
        REG_TY:  ty_d  = cfg_data_i;
        REG_TZ:  tz_d  = cfg_data_i;
        REG_RAD: rad_d = cfg_data_i[30:0];
        REG_POLAR: begin
          if (cfg_data_i[15:0] < POLAR_MIN)      pol_d = POLAR_MIN;
          else if (cfg_data_i[15:0] > POLAR_MAX) pol_d = POLAR_MAX;
          else                                   pol_d = cfg_data_i[15:0];
        end
        REG_AZ:  az_d = cfg_data_i[17:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (pol_sum < $signed({3'b0, POLAR_MIN}))      pol_d = POLAR_MIN;
          else if (pol_sum > $signed({3'b0, POLAR_MAX})) pol_d = POLAR_MAX;
          else                                           pol_d = pol_sum[15:0];
          if (az_sum > DEG720_S)       az_d = 18'(az_sum - DEG720_S);
          else if (az_sum > DEG360_S)  az_d = 18'(az_sum - DEG360_S);
          else if (az_sum < -DEG720_S) az_d = 18'(az_sum + DEG720_S);
          else if (az_sum < -DEG360_S) az_d = 18'(az_sum + DEG360_S);
          else                         az_d = 18'(az_sum);
          pass_d  = 1'b0;
          state_d = S_RED;
        end
      end
      S_RED: begin
        quad_d = quad;
        swap_d = r_full > DEG45;
        r_d    = swap_d ? 14'(DEG90 - r_full) : 14'(r_full);
        ma_d = K_HI; mb_d = 64'(r_d); acc_d = '0; cnt_d = '0;
        ret_d = S_XB; state_d = S_MQ;
      end
      S_XB: begin
        x_d  = acc_q[63:0];
        ma_d = K_LO; mb_d = 64'(r_q); acc_d = '0; cnt_d = '0;
        ret_d = S_XC; state_d = S_MQ;
      end
      S_XC: begin
        dq_d = acc_q[63:0]; dv_d = DIV_RAD;
        ret_d = S_XD; state_d = S_DIV;
      end
      S_XD: begin
        x_d  = x_q + dq_q;
        ma_d = x_d; mb_d = x_d; acc_d = '0; cnt_d = '0;
        ret_d = S_X2; state_d = S_MQ;
      end
      S_X2: begin
        x2_d = mq; ts_d = x_q; tc_d = ONE_Q60; ss_d = x_q; cc_d = ONE_Q60; k_d = 4'd1;
        ma_d = x_q; mb_d = mq; acc_d = '0; cnt_d = '0;
        ret_d = S_S2; state_d = S_MQ;
      end
      S_S2: begin
        dq_d = mq; dv_d = 16'(d_s);
        ret_d = S_S3; state_d = S_DIV;
      end
      S_S3: begin
        ts_d = dq_q;
        ss_d = k_q[0] ? ss_q - dq_q : ss_q + dq_q;
        ma_d = tc_q; mb_d = x2_q; acc_d = '0; cnt_d = '0;
        ret_d = S_C2; state_d = S_MQ;
      end
      S_C2: begin
        dq_d = mq; dv_d = 16'(d_c);
        ret_d = S_C3; state_d = S_DIV;
      end
      S_C3: begin
        tc_d = dq_q;
        cc_d = k_q[0] ? cc_q - dq_q : cc_q + dq_q;
        if (k_q == TERMS) begin
          state_d = S_FIN;
        end else begin
          k_d  = k_q + 4'd1;
          ma_d = ts_q; mb_d = x2_q; acc_d = '0; cnt_d = '0;
          ret_d = S_S2; state_d = S_MQ;
        end
      end
      S_FIN: begin
        if (!pass_q) begin
          st_d = so; ct_d = co; pass_d = 1'b1; state_d = S_RED;
        end else begin
          sp_d = so; cp_d = co; p_d = '0; state_d = S_PR;
        end
      end
      S_PR: begin
        unique case (p_q)
          2'd0: ctsp_d = TW'(rp >>> FRAC_BITS);
          2'd1: ctcp_d = TW'(rp >>> FRAC_BITS);
          2'd2: stsp_d = TW'(rp >>> FRAC_BITS);
          default: stcp_d = TW'(rp >>> FRAC_BITS);
        endcase
        p_d = p_q + 2'd1;
        if (p_q == 2'd3) begin
          j_d = '0; n_d = '0; acc_d = '0; state_d = S_TR;
        end
      end
      S_TR: begin
        acc_d = acc_q + pp;
        n_d   = n_q + 2'd1;
        if (n_q == 2'd2) state_d = S_TRE;
      end
      S_TRE: begin
        if (out_free) begin
          ov_d = 1'b1; oidx_d = j_q; oc3_d = col3; opol_d = pol_q; oaz_d = az_q;
          unique case (j_q)
            2'd0: begin oc0_d = 32'(cp_q); oc1_d = '0; oc2_d = 32'(-sp_q); end
            2'd1: begin oc0_d = 32'(-ctsp_q); oc1_d = 32'(st_q); oc2_d = 32'(-ctcp_q); end
            default: begin oc0_d = 32'(stsp_q); oc1_d = 32'(ct_q); oc2_d = 32'(stcp_q); end
          endcase
          if (j_q == 2'd2) begin
            state_d = S_ROW3;
          end else begin
            j_d = j_q + 2'd1; n_d = '0; acc_d = '0; state_d = S_TR;
          end
        end
      end
      S_ROW3: begin
        if (out_free) begin
          ov_d = 1'b1; oidx_d = 2'd3; oc0_d = '0; oc1_d = '0; oc2_d = 32'(cf_j);
          oc3_d = 32'sd1 <<< FRAC_BITS; opol_d = pol_q; oaz_d = az_q;
          state_d = S_IDLE;
        end
      end
      S_MQ: begin
        acc_d = acc_q + pp;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) state_d = ret_q;
      end
      // quotient estimate: floor(n * rcp / 2^64) is q or q - 1
      S_DIV: begin
        nd_d = dq_q;
        ma_d = dq_q; mb_d = rcp; acc_d = '0; cnt_d = '0;
        dret_d = ret_q; ret_d = S_DV1; state_d = S_MQ;
      end
      S_DV1: begin
        dq_d = acc_q[127:64];
        ma_d = acc_q[127:64]; mb_d = {48'b0, dv_q}; acc_d = '0; cnt_d = '0;
        ret_d = S_DV2; state_d = S_MQ;
      end
      S_DV2: begin
        if (dv_rem >= {48'b0, dv_q}) dq_d = dq_q + 64'd1;
        state_d = dret_q;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      dret_q  <= S_IDLE;
      tx_q    <= '0;
      ty_q    <= '0;
      tz_q    <= '0;
      rad_q   <= RAD_RST;
      pol_q   <= POLAR_RST;
      az_q    <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
      pass_q  <= 1'b0;
      p_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      dret_q  <= dret_d;
      tx_q    <= tx_d;
      ty_q    <= ty_d;
      tz_q    <= tz_d;
      rad_q   <= rad_d;
      pol_q   <= pol_d;
      az_q    <= az_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      pass_q  <= pass_d;
      p_q     <= p_d;
      j_q     <= j_d;
      n_q     <= n_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q <= ma_d; mb_q <= mb_d; acc_q <= acc_d;
    dq_q <= dq_d; nd_q <= nd_d; dv_q <= dv_d;
    x_q <= x_d; x2_q <= x2_d; ts_q <= ts_d; tc_q <= tc_d; ss_q <= ss_d; cc_q <= cc_d;
    r_q <= r_d; swap_q <= swap_d; quad_q <= quad_d;
    st_q <= st_d; ct_q <= ct_d; sp_q <= sp_d; cp_q <= cp_d;
    ctsp_q <= ctsp_d; ctcp_q <= ctcp_d; stsp_q <= stsp_d; stcp_q <= stcp_d;
    oidx_q <= oidx_d; oc0_q <= oc0_d; oc1_q <= oc1_d; oc2_q <= oc2_d; oc3_q <= oc3_d;
    opol_q <= opol_d; oaz_q <= oaz_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = oidx_q;
  assign m_axis_tlast  = (oidx_q == 2'd3);
  assign m_axis_tdata  = {6'b0, oaz_q, opol_q, oc3_q, oc2_q, oc1_q, oc0_q};

endmodule

// ----- sv/ocvm_chk.sv -----
module ocvm_chk #(
  parameter int FRAC_BITS = 16
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [ocvm_pkg::OUT_W-1:0] m_axis_tdata,
  input logic [1:0]                 m_axis_tuser,
  input logic                       m_axis_tlast
);
  import ocvm_pkg::*;

  a_last_row3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 2'd3)))
    else $error("tlast does not match row index");

  a_row3_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == 2'd3 |->
      m_axis_tdata[127:96] == (32'd1 << FRAC_BITS))
    else $error("constant row translation wrong");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready while transaction in work");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser != 2'd3 |=>
      !m_axis_tvalid || m_axis_tuser == $past(m_axis_tuser) + 2'd1)
    else $error("row order broken");

endmodule

bind orbit_camera_view_matrix_core ocvm_chk #(.FRAC_BITS(FRAC_BITS)) u_ocvm_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/sv/view_matrix_checker.sv -----
`timescale 1ns / 100ps

module view_matrix_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ocvm_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  logic [ocvm_pkg::CDAT_W-1:0]  cfg_data_i,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [ocvm_pkg::IN_W-1:0]    s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [ocvm_pkg::OUT_W-1:0]   m_axis_tdata,
  input  logic [1:0]                   m_axis_tuser,
  input  logic                         m_axis_tlast,
  output int                           err_count_o,
  output int                           rows_pending_o
);
  import ocvm_pkg::*;

  localparam int FRAC = 16;
  localparam int FULL_TURN = 92160;
  localparam int QUARTER = 23040;
  localparam int EIGHTH = 11520;
  localparam int HALF_RAD = 46080;
  localparam int P_LO = 1280;
  localparam int P_HI = 44800;
  localparam longint unsigned PI_FX = 64'h3243F6A8885A308D;
  localparam longint unsigned ONE_FX = 64'h1000000000000000;
  localparam longint unsigned STEP_HI = PI_FX / 64'd46080;
  localparam longint unsigned STEP_LO = PI_FX % 64'd46080;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] col [4];
    logic [15:0] polar;
    logic [17:0] azim;
    logic        last;
  } mat_row_t;

  mat_row_t row_q[$];

  longint tgt_x, tgt_y, tgt_z, radius;
  int     polar_st, azim_st;

  assign rows_pending_o = row_q.size();

  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic int clamp_polar(longint v);
    if (v < P_LO) return P_LO;
    if (v > P_HI) return P_HI;
    return int'(v);
  endfunction

  function automatic longint round_fx(longint v);
    return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic series_trig(input int r, output longint s, output longint c);
    longint unsigned x, x2, ts, tc, ss, cc, ur;
    ur = longint'(r);
    x = STEP_HI * ur + (STEP_LO * ur) / longint'(HALF_RAD);
    x2 = fx_mul(x, x);
    ts = x; tc = ONE_FX; ss = x; cc = ONE_FX;
    for (int k = 1; k <= 12; k++) begin
      ts = fx_mul(ts, x2) / longint'((2 * k) * (2 * k + 1));
      tc = fx_mul(tc, x2) / longint'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        ss -= ts; cc -= tc;
      end else begin
        ss += ts; cc += tc;
      end
    end
    s = longint'((ss + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
    c = longint'((cc + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
  endtask

  task automatic angle_trig(input int a, output longint s, output longint c);
    int m, q, r;
    longint s0, c0;
    m = a % FULL_TURN;
    if (m < 0) m += FULL_TURN;
    q = m / QUARTER;
    r = m % QUARTER;
    if (r <= EIGHTH) series_trig(r, s0, c0);
    else series_trig(QUARTER - r, c0, s0);
    case (q % 4)
      0: begin s = s0;  c = c0;  end
      1: begin s = c0;  c = -s0; end
      2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endtask

  task automatic predict_rows(input logic [IN_W-1:0] d);
    longint st, ct, sp, cp, ctsp, ctcp, stsp, stcp, az;
    longint m [4][4];
    mat_row_t r;
    az = longint'(azim_st) + longint'($signed(d[17:0]));
    polar_st = clamp_polar(longint'(polar_st) + longint'($signed(d[35:18])));
    while (az > FULL_TURN) az -= FULL_TURN;
    while (az < -FULL_TURN) az += FULL_TURN;
    azim_st = int'(az);
    angle_trig(polar_st, st, ct);
    angle_trig(azim_st, sp, cp);
    ctsp = round_fx(ct * sp);
    ctcp = round_fx(ct * cp);
    stsp = round_fx(st * sp);
    stcp = round_fx(st * cp);
    m[0][0] = cp;    m[0][1] = 0;  m[0][2] = -sp;
    m[0][3] = -round_fx(tgt_x * cp - tgt_z * sp);
    m[1][0] = -ctsp; m[1][1] = st; m[1][2] = -ctcp;
    m[1][3] = -round_fx(-tgt_x * ctsp + tgt_y * st - tgt_z * ctcp);
    m[2][0] = stsp;  m[2][1] = ct; m[2][2] = stcp;
    m[2][3] = -round_fx(tgt_x * stsp + tgt_y * ct + tgt_z * stcp) - radius;
    m[3][0] = 0;     m[3][1] = 0;  m[3][2] = 0;
    m[3][3] = 64'sd1 <<< FRAC;
    for (int k = 0; k < 4; k++) begin
      r.row = k[1:0];
      for (int j = 0; j < 4; j++) r.col[j] = 32'(sat32(m[k][j]));
      r.polar = polar_st[15:0];
      r.azim = azim_st[17:0];
      r.last = (k == 3);
      row_q.push_back(r);
    end
  endtask

  task automatic report(input string fld, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      err_count_o++;
      if (err_count_o <= 10)
        $display("mismatch %s: expected %h, got %h", fld, e, a);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_x = 0; tgt_y = 0; tgt_z = 0;
      radius = longint'(RAD_RST);
      polar_st = clamp_polar(longint'(POLAR_RST));
      azim_st = 0;
      row_q.delete();
      err_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TX:    tgt_x = longint'($signed(cfg_data_i));
          REG_TY:    tgt_y = longint'($signed(cfg_data_i));
          REG_TZ:    tgt_z = longint'($signed(cfg_data_i));
          REG_RAD:   radius = longint'({33'd0, cfg_data_i[30:0]});
          REG_POLAR: polar_st = clamp_polar(longint'(cfg_data_i[15:0]));
          REG_AZ:    azim_st = int'($signed(cfg_data_i[17:0]));
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_rows(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (row_q.size() == 0) begin
          err_count_o++;
          if (err_count_o <= 10) $display("unexpected output transaction");
        end else begin
          mat_row_t e;
          e = row_q.pop_front();
          report("row", 32'(e.row), 32'(m_axis_tuser));
          report("col0", e.col[0], m_axis_tdata[31:0]);
          report("col1", e.col[1], m_axis_tdata[63:32]);
          report("col2", e.col[2], m_axis_tdata[95:64]);
          report("col3", e.col[3], m_axis_tdata[127:96]);
          report("polar", 32'(e.polar), 32'(m_axis_tdata[143:128]));
          report("azimuth", 32'(e.azim), 32'(m_axis_tdata[161:144]));
          report("last", 32'(e.last), 32'(m_axis_tlast));
        end
      end
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import ocvm_pkg::*;

  localparam logic [CIDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CIDX_W-1:0] REG_UNUSED_B = 3'd7;
  localparam int FULL_TURN = 92160;
  localparam int STALL_LIMIT = 40000;

  logic               clk_i, rst_ni;
  logic               cfg_we_i;
  logic [CIDX_W-1:0]  cfg_idx_i;
  logic [CDAT_W-1:0]  cfg_data_i;
  logic               s_axis_tvalid, s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata;
  logic               m_axis_tvalid, m_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic [1:0]         m_axis_tuser;
  logic               m_axis_tlast;
  int                 err_count, rows_pending;
  int                 tx_idle, rx_idle, quiet;

  orbit_camera_view_matrix_core dut (.*);

  view_matrix_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .err_count_o(err_count), .rows_pending_o(rows_pending)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic cfg_done();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_move(input int daz, input int dpol);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, 18'(dpol), 18'(daz)};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (rows_pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic int wide_delta();
    return int'($urandom_range(2 * FULL_TURN)) - FULL_TURN;
  endfunction

  function automatic int near_delta();
    return int'($urandom_range(8000)) - 4000;
  endfunction

  task automatic random_moves(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) send_move(wide_delta(), wide_delta());
      else send_move(near_delta(), near_delta());
    end
  endtask

  task automatic random_setup();
    cfg_write(REG_TX, $urandom);
    cfg_write(REG_TY, $urandom);
    cfg_write(REG_TZ, $urandom_range(1) ? $urandom : $urandom_range(2000000));
    cfg_write(REG_RAD, $urandom);
    cfg_write(REG_POLAR, $urandom_range(50000));
    cfg_write(REG_AZ, 32'(wide_delta()));
    cfg_done();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    tx_idle = 8;
    rx_idle = 79;
    quiet = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults, then angle extremes and wraps
    send_move(0, 0);
    send_move(FULL_TURN, 0);
    send_move(FULL_TURN, FULL_TURN);
    send_move(-FULL_TURN, -FULL_TURN);
    send_move(-FULL_TURN, 0);
    send_move(-FULL_TURN, 200);
    send_move(FULL_TURN, 46080);
    send_move(11520, -23040);
    send_move(1, -1);
    drain();

    cfg_write(REG_TX, 32'h7FFF_FFFF);
    cfg_write(REG_TY, 32'h8000_0000);
    cfg_write(REG_TZ, 32'h7FFF_FFFF);
    cfg_write(REG_RAD, 32'hFFFF_FFFF);
    cfg_write(REG_POLAR, 32'h0000_FFFF);
    cfg_write(REG_AZ, 32'(-FULL_TURN));
    cfg_write(REG_UNUSED_A, 32'h1234_5678);
    cfg_done();
    send_move(0, 0);
    send_move(-FULL_TURN, -1000);
    send_move(FULL_TURN, -FULL_TURN);
    send_move(5760, 23040);
    drain();

    cfg_write(REG_TX, 32'h8000_0000);
    cfg_write(REG_TY, 32'h7FFF_FFFF);
    cfg_write(REG_TZ, 32'h8000_0000);
    cfg_write(REG_RAD, 32'h0);
    cfg_write(REG_POLAR, 32'h0);
    cfg_write(REG_AZ, 32'(FULL_TURN));
    cfg_write(REG_UNUSED_B, 32'hFFFF_FFFF);
    cfg_done();
    send_move(0, 0);
    send_move(FULL_TURN, 43520);
    send_move(-3, 1);
    send_move(34560, -11520);
    drain();

    random_setup();
    random_moves(28);
    drain();

    tx_idle = 79;
    rx_idle = 8;
    random_setup();
    random_moves(28);
    drain();

    tx_idle = 0;
    rx_idle = 0;
    cfg_write(REG_TX, 32'h0);
    cfg_write(REG_TY, 32'h0);
    cfg_write(REG_TZ, 32'h0);
    cfg_write(REG_RAD, 32'd1);
    cfg_write(REG_POLAR, 32'd1280);
    cfg_write(REG_AZ, 32'd0);
    cfg_done();
    random_moves(14);
    drain();
    random_setup();
    random_moves(14);
    drain();

    repeat (100) @(posedge clk_i);
    if (err_count == 0 && rows_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
